### src/attitude_p_control_motor_mix_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the attitude controller and motor mixer
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ATTITUDE_P_CONTROL_MOTOR_MIX_DEFINES_SVH
`define ATTITUDE_P_CONTROL_MOTOR_MIX_DEFINES_SVH

// Same-cycle implication.
`define APCMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/apcmm_pkg.sv
// ----------------------------------------------------------------------------
// apcmm_pkg
// Types and constants shared by the attitude controller and motor mixer.
// ----------------------------------------------------------------------------
package apcmm_pkg;

  localparam int unsigned FieldW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RadW     = 32;
  localparam int unsigned RemW     = 18;
  localparam int unsigned RootW    = 16;
  localparam int unsigned NumCells = RootW;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_ROLL   = 8'd0,
    CFG_KP_PITCH  = 8'd1,
    CFG_KP_YAW    = 8'd2,
    CFG_YAW_LIMIT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [FieldW-1:0] desired_roll;
    logic signed [FieldW-1:0] desired_pitch;
    logic signed [FieldW-1:0] desired_yaw;
    logic signed [FieldW-1:0] thrust_demand;
    logic signed [FieldW-1:0] measured_roll;
    logic signed [FieldW-1:0] measured_pitch;
    logic signed [FieldW-1:0] measured_yaw;
    logic signed [FieldW-1:0] quat_x;
    logic signed [FieldW-1:0] quat_y;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] motor_front;
    logic [FieldW-1:0] motor_back;
    logic [FieldW-1:0] motor_right;
    logic [FieldW-1:0] motor_left;
  } out_item_t;

  typedef struct packed {
    logic [15:0] kp_roll;
    logic [15:0] kp_pitch;
    logic [15:0] kp_yaw;
    logic [14:0] yaw_error_limit;
  } cfg_t;

  // Rounded proportional terms carried alongside the root computation.
  typedef struct packed {
    logic signed [30:0] t_roll;
    logic signed [30:0] t_pitch;
    logic signed [24:0] t_yaw;
  } terms_t;

  // State handed from one square-root cell to the next.
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    terms_t           terms;
  } cell_t;

endpackage

### src/attitude_p_control_motor_mix.sv
// ----------------------------------------------------------------------------
// attitude_p_control_motor_mix
// Proportional attitude controller with a four-motor mixer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_stall_o     in_data_i  (apcmm_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i   out_data_o (apcmm_pkg::out_item_t)
// cfg       input      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// The block takes one transfer per cycle unless the input stalls, and each
// result passes through three front-end stages, sixteen root cells and
// the output register. Most of that depth is the sixteen-cell square-root
// chain, which resolves one root bit per cell.
// Reset clears every stage valid flag and loads the register defaults.
// A stall at the output only holds the stages that are full; bubbles ahead
// of the stall keep closing, so the input stalls only when all stages hold
// an item.
// ----------------------------------------------------------------------------
`include "attitude_p_control_motor_mix_defines.svh"

module attitude_p_control_motor_mix #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  apcmm_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output apcmm_pkg::out_item_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [apcmm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [apcmm_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import apcmm_pkg::*;

  // Default yaw clamp is one tenth of unity, rounded.
  localparam logic [14:0] YawLimitRst = 15'(((1 << FRACTION_BITS) + 5) / 10);

  localparam int unsigned FrontStages = 3;
  localparam int unsigned NumStages   = FrontStages + NumCells + 1;
  localparam int unsigned OutStage    = NumStages - 1;

  cfg_t cfg_q;

  // Valid flag per stage; a stage loads whenever it is free or its
  // successor is moving.
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] ready;

  cell_t     cell_w [NumCells+1];
  out_item_t out_q, out_d;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_roll         <= 16'd256;
      cfg_q.kp_pitch        <= 16'd256;
      cfg_q.kp_yaw          <= 16'd256;
      cfg_q.yaw_error_limit <= YawLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KP_ROLL:   cfg_q.kp_roll         <= cfg_wdata_i;
        CFG_KP_PITCH:  cfg_q.kp_pitch        <= cfg_wdata_i;
        CFG_KP_YAW:    cfg_q.kp_yaw          <= cfg_wdata_i;
        CFG_YAW_LIMIT: cfg_q.yaw_error_limit <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // A stage may load if the output is free to move or some stage at or
  // after it is empty.
  for (genvar k = 0; k < NumStages; k++) begin : g_ready
    assign ready[k] = !out_stall_i || !(&valid_q[NumStages-1:k]);
  end

  always_comb begin
    valid_d = valid_q;
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = !ready[0];

  apcmm_front u_front (
    .clk_i    (clk_i),
    .en_i     (ready[FrontStages-1:0]),
    .in_data_i(in_data_i),
    .cfg_i    (cfg_q),
    .cell_o   (cell_w[0])
  );

  // The square-root chain: each cell settles one root bit and hands the
  // partial remainder to its neighbor.
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    apcmm_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ready[FrontStages+c]),
      .cell_i(cell_w[c]),
      .cell_o(cell_w[c+1])
    );
  end

  function automatic logic [FieldW-1:0] sat16(input logic signed [32:0] v);
    logic [FieldW-1:0] r;
    priority if (v < 0) begin
      r = '0;
    end else if (v > 33'sd65535) begin
      r = '1;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

  // Mixer: the base level is the finished root, combined with the terms
  // that traveled through the chain.
  logic signed [32:0] base, t_roll, t_pitch, t_yaw;

  always_comb begin
    base    = signed'({17'd0, cell_w[NumCells].root});
    t_roll  = 33'(cell_w[NumCells].terms.t_roll);
    t_pitch = 33'(cell_w[NumCells].terms.t_pitch);
    t_yaw   = 33'(cell_w[NumCells].terms.t_yaw);
    out_d.motor_front = sat16(base + t_yaw + t_pitch);
    out_d.motor_back  = sat16(base + t_yaw - t_pitch);
    out_d.motor_right = sat16(base - t_roll - t_yaw);
    out_d.motor_left  = sat16(base + t_roll - t_yaw);
  end

  always_ff @(posedge clk_i) begin
    if (ready[OutStage]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[OutStage];
  assign out_data_o  = out_q;

  // An accepted transfer lands in the first stage.
  `APCMM_ASSERT_NEXT(a_in_lands, in_valid_i && !in_stall_o, valid_q[0],
                     "accepted input did not enter the first stage")

  // The input only stalls when every stage holds an item.
  `APCMM_ASSERT_IMP(a_stall_full, in_stall_o, &valid_q,
                    "input stalled while the pipeline has a bubble")

  // A delivered result with nothing behind it leaves the output empty.
  `APCMM_ASSERT_NEXT(a_out_drain,
                     out_valid_o && !out_stall_i && !valid_q[OutStage-1],
                     !out_valid_o, "output register did not drain")

endmodule

### src/apcmm_front.sv
// ----------------------------------------------------------------------------
// apcmm_front
// Three-stage front end: errors and yaw clamp, products and squares,
// rounded proportional terms and the radicand for the root chain.
// ----------------------------------------------------------------------------
module apcmm_front (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  apcmm_pkg::in_item_t in_data_i,
  input  apcmm_pkg::cfg_t     cfg_i,
  output apcmm_pkg::cell_t    cell_o
);
  import apcmm_pkg::*;

  // Stage A registers.
  logic signed [16:0] e_roll_q, e_pitch_q, e_yaw_q;
  logic signed [16:0] e_roll_d, e_pitch_d, e_yaw_d;
  logic signed [15:0] thrust_q, qx_q, qy_q;

  // Stage B registers.
  logic signed [33:0] p_roll_q, p_pitch_q, p_yaw_q;
  logic        [30:0] sq_t_q, sq_x_q, sq_y_q;
  logic signed [31:0] sq_t_w, sq_x_w, sq_y_w;

  // Stage C.
  logic signed [38:0] r20_roll, r20_pitch;
  logic signed [33:0] r_yaw;
  cell_t              cell_d, cell_q;
  logic signed [16:0] lim;
  logic signed [16:0] e_yaw_raw;

  always_comb begin
    lim       = signed'({2'b00, cfg_i.yaw_error_limit});
    e_roll_d  = 17'(in_data_i.desired_roll)  - 17'(in_data_i.measured_roll);
    e_pitch_d = 17'(in_data_i.desired_pitch) - 17'(in_data_i.measured_pitch);
    e_yaw_raw = 17'(in_data_i.desired_yaw)   - 17'(in_data_i.measured_yaw);
    priority if (e_yaw_raw > lim) begin
      e_yaw_d = lim;
    end else if (e_yaw_raw < -lim) begin
      e_yaw_d = -lim;
    end else begin
      e_yaw_d = e_yaw_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e_roll_q  <= e_roll_d;
      e_pitch_q <= e_pitch_d;
      e_yaw_q   <= e_yaw_d;
      thrust_q  <= in_data_i.thrust_demand;
      qx_q      <= in_data_i.quat_x;
      qy_q      <= in_data_i.quat_y;
    end
  end

  assign sq_t_w = thrust_q * thrust_q;
  assign sq_x_w = qx_q * qx_q;
  assign sq_y_w = qy_q * qy_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_roll_q  <= signed'({1'b0, cfg_i.kp_roll})  * e_roll_q;
      p_pitch_q <= signed'({1'b0, cfg_i.kp_pitch}) * e_pitch_q;
      p_yaw_q   <= signed'({1'b0, cfg_i.kp_yaw})   * e_yaw_q;
      sq_t_q    <= sq_t_w[30:0];
      sq_x_q    <= sq_x_w[30:0];
      sq_y_q    <= sq_y_w[30:0];
    end
  end

  // Times twenty as two shifted copies; the half-LSB offset then a floor shift
  // rounds to nearest with ties toward plus infinity.
  always_comb begin
    r20_roll  = (39'(p_roll_q) <<< 4) + (39'(p_roll_q) <<< 2) + 39'sd128;
    r20_pitch = (39'(p_pitch_q) <<< 4) + (39'(p_pitch_q) <<< 2) + 39'sd128;
    r_yaw     = p_yaw_q + 34'sd256;
    cell_d.terms.t_roll  = r20_roll[38:8];
    cell_d.terms.t_pitch = r20_pitch[38:8];
    cell_d.terms.t_yaw   = r_yaw[33:9];
    cell_d.rad  = 32'(sq_t_q) + 32'(sq_x_q) + 32'(sq_y_q);
    cell_d.rem  = '0;
    cell_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/apcmm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// apcmm_sqrt_cell
// One restoring square-root step: brings down two radicand bits and
// decides one root bit. The proportional terms ride along unchanged.
// ----------------------------------------------------------------------------
module apcmm_sqrt_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  apcmm_pkg::cell_t cell_i,
  output apcmm_pkg::cell_t cell_o
);
  import apcmm_pkg::*;

  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;
  logic            fits;
  cell_t           cell_d, cell_q;

  always_comb begin
    rem_sh = {cell_i.rem, cell_i.rad[RadW-1 -: 2]};
    trial  = {2'b00, cell_i.root, 2'b01};
    fits   = (rem_sh >= trial);
    cell_d       = cell_i;
    cell_d.rad   = {cell_i.rad[RadW-3:0], 2'b00};
    cell_d.root  = {cell_i.root[RootW-2:0], fits};
    cell_d.rem   = fits ? RemW'(rem_sh - trial) : RemW'(rem_sh);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### verif/tb_attitude_p_control_motor_mix.sv
// ----------------------------------------------------------------------------
// Testbench for the attitude controller and motor mixer
// Drives attitude samples through the valid/stall input channel, checks
// each set of motor drives against a cycle-free model of the proportional
// law and the mixer, and walks the gain registers through several settings.
// ----------------------------------------------------------------------------
module tb_attitude_p_control_motor_mix;
  import apcmm_pkg::*;

  // Input transfer to result, through every pipeline stage of the block.
  localparam int PipeDepth     = 20;
  localparam int SettleCycles  = PipeDepth + 4;
  localparam int NumRows       = 20;
  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 190;
  localparam int TimeoutCycles = 200000;
  localparam int MaxReports    = 10;
  // First register index past the end of the register list.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = CfgIdxW'(CFG_YAW_LIMIT + 1);

  localparam logic signed [FieldW-1:0] SMax = 16'sh7FFF;
  localparam logic signed [FieldW-1:0] SMin = 16'sh8000;
  localparam logic signed [FieldW-1:0] SZero = 16'sh0000;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t drives;
  } sample_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // Local copy of the gain registers, kept in step with every write.
  logic [15:0] gain_roll;
  logic [15:0] gain_pitch;
  logic [15:0] gain_yaw;
  logic [14:0] yaw_limit;

  out_item_t   pending_drives[$];
  sample_row_t rows [NumRows];
  int          fail_cnt;
  int          send_idle_pct;
  int          stall_pct;

  attitude_p_control_motor_mix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // A motor sum below zero shuts the motor off; above full scale it pins.
  function automatic logic [15:0] drive_level(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Proportional law plus mixer for one attitude sample under the current
  // register settings.
  function automatic out_item_t mix_motors(in_item_t s);
    longint err_roll, err_pitch, err_yaw, lim;
    longint term_roll, term_pitch, term_yaw, base, t, qx, qy;
    longint unsigned energy, root, trial;
    out_item_t d;
    err_roll  = longint'($signed(s.desired_roll)) - longint'($signed(s.measured_roll));
    err_pitch = longint'($signed(s.desired_pitch)) - longint'($signed(s.measured_pitch));
    err_yaw   = longint'($signed(s.desired_yaw)) - longint'($signed(s.measured_yaw));
    lim = longint'(yaw_limit);
    if (err_yaw > lim) err_yaw = lim;
    else if (err_yaw < -lim) err_yaw = -lim;
    // Adding half an LSB and then an arithmetic shift rounds ties upward.
    term_roll  = (20 * longint'(gain_roll) * err_roll + 128) >>> 8;
    term_pitch = (20 * longint'(gain_pitch) * err_pitch + 128) >>> 8;
    term_yaw   = (longint'(gain_yaw) * err_yaw + 256) >>> 9;
    t  = longint'($signed(s.thrust_demand));
    qx = longint'($signed(s.quat_x));
    qy = longint'($signed(s.quat_y));
    energy = longint'(t * t + qx * qx + qy * qy);
    // The root of three full-scale squares still fits in sixteen bits.
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= energy) root = trial;
    end
    base = longint'(root);
    d.motor_front = drive_level(base + term_yaw + term_pitch);
    d.motor_back  = drive_level(base + term_yaw - term_pitch);
    d.motor_right = drive_level(base - term_roll - term_yaw);
    d.motor_left  = drive_level(base + term_roll - term_yaw);
    return d;
  endfunction

  function automatic logic [15:0] jitter(int center, int span);
    return 16'(center + int'($urandom_range(2 * span)) - span);
  endfunction

  // Most samples look like a vehicle in flight: measured angles close to
  // the targets, moderate thrust, a small tilt. The rest are raw noise and
  // corner values so that every bit of every field toggles.
  function automatic in_item_t draw_attitude();
    in_item_t it;
    int mode, span, cr, cp, cy;
    mode = $urandom_range(9);
    if (mode < 6) begin
      span = ($urandom_range(3) == 0) ? 2048 : 96;
      cr = int'($urandom_range(16384)) - 8192;
      cp = int'($urandom_range(16384)) - 8192;
      cy = int'($urandom_range(16384)) - 8192;
      it.desired_roll   = 16'(cr);
      it.desired_pitch  = 16'(cp);
      it.desired_yaw    = 16'(cy);
      it.measured_roll  = jitter(cr, span);
      it.measured_pitch = jitter(cp, span);
      it.measured_yaw   = jitter(cy, span);
      it.thrust_demand  = jitter(6144, 8192);
      it.quat_x         = jitter(0, 2048);
      it.quat_y         = jitter(0, 2048);
    end else begin
      for (int f = 0; f < 9; f++) begin
        if (mode < 8) begin
          it[16*f +: 16] = 16'($urandom);
        end else begin
          case ($urandom_range(4))
            0: it[16*f +: 16] = SMin;
            1: it[16*f +: 16] = SMax;
            2: it[16*f +: 16] = SZero;
            3: it[16*f +: 16] = 16'hFFFF;
            default: it[16*f +: 16] = 16'($urandom);
          endcase
        end
      end
    end
    return it;
  endfunction

  // Offers one sample on the input channel. The idle decision is made
  // before the stall is seen, so valid never depends on stall, and the
  // payload holds until the transfer completes.
  task automatic send_sample(in_item_t it, out_item_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    pending_drives.push_back(want);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    case (idx)
      CFG_KP_ROLL:   gain_roll  = data;
      CFG_KP_PITCH:  gain_pitch = data;
      CFG_KP_YAW:    gain_yaw   = data;
      CFG_YAW_LIMIT: yaw_limit  = data[14:0];
      default: ;
    endcase
  endtask

  // A write past the register list goes first and must leave every gain
  // untouched; the yaw limit write may carry a top bit that gets dropped.
  task automatic program_gains(logic [15:0] kr, logic [15:0] kpi, logic [15:0] ky,
                               logic [15:0] lim);
    write_reg(CfgIdxUnused + CfgIdxW'($urandom_range(255 - CfgIdxUnused)), 16'($urandom));
    write_reg(CFG_KP_ROLL, kr);
    write_reg(CFG_KP_PITCH, kpi);
    write_reg(CFG_KP_YAW, ky);
    write_reg(CFG_YAW_LIMIT, lim);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Stops offering samples and waits until every outstanding result is in,
  // then lets the pipeline run empty for a while.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The receiver stalls at random; the rate is set by the main sequence.
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // Every output transfer is matched against the oldest outstanding
  // prediction, field by field.
  always @(posedge clk_i) begin : check_drives
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("motor drives f=%0d b=%0d r=%0d l=%0d arrived with nothing outstanding",
                   out_data_o.motor_front, out_data_o.motor_back,
                   out_data_o.motor_right, out_data_o.motor_left);
      end else begin
        want = pending_drives.pop_front();
        if (out_data_o.motor_front !== want.motor_front ||
            out_data_o.motor_back  !== want.motor_back  ||
            out_data_o.motor_right !== want.motor_right ||
            out_data_o.motor_left  !== want.motor_left) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("drive mismatch: want f=%0d b=%0d r=%0d l=%0d, got f=%0d b=%0d r=%0d l=%0d",
                     want.motor_front, want.motor_back, want.motor_right, want.motor_left,
                     out_data_o.motor_front, out_data_o.motor_back,
                     out_data_o.motor_right, out_data_o.motor_left);
        end
      end
    end
  end

  initial begin
    #(2 * TimeoutCycles);
    $display("tb_attitude_p_control_motor_mix failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    fail_cnt      = 0;
    // Sender idles lightly, receiver stalls heavily for the first third.
    send_idle_pct = 20;
    stall_pct     = 55;
    // Register defaults after reset: unity gains, yaw clamp at 0.1 rad.
    gain_roll     = 16'd256;
    gain_pitch    = 16'd256;
    gain_yaw      = 16'd256;
    yaw_limit     = 15'd410;

    // Directed samples. Field order is desired roll, pitch, yaw, thrust,
    // measured roll, pitch, yaw, quaternion x, y. Drives are front, back,
    // right, left, and are written out only where they follow directly
    // from the reset gains; the other rows go through the predictor.
    rows[0]  = '{'{SZero, SZero, SZero, SZero, SZero, SZero, SZero, SZero, SZero},
                 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}};
    // Pure thrust, both signs: a negative demand only enters squared.
    rows[1]  = '{'{SZero, SZero, SZero, SMax, SZero, SZero, SZero, SZero, SZero},
                 1'b1, '{16'd32767, 16'd32767, 16'd32767, 16'd32767}};
    rows[2]  = '{'{SZero, SZero, SZero, SMin, SZero, SZero, SZero, SZero, SZero},
                 1'b1, '{16'd32768, 16'd32768, 16'd32768, 16'd32768}};
    // Largest possible base level: three full-scale negative components.
    rows[3]  = '{'{SZero, SZero, SZero, SMin, SZero, SZero, SZero, SMin, SMin},
                 1'b1, '{16'd56755, 16'd56755, 16'd56755, 16'd56755}};
    // Full-scale roll and pitch errors saturate one motor and cut another.
    rows[4]  = '{'{SMax, SZero, SZero, SZero, SMin, SZero, SZero, SZero, SZero},
                 1'b1, '{16'd0, 16'd0, 16'd0, 16'd65535}};
    rows[5]  = '{'{SMin, SZero, SZero, SZero, SMax, SZero, SZero, SZero, SZero},
                 1'b1, '{16'd0, 16'd0, 16'd65535, 16'd0}};
    rows[6]  = '{'{SZero, SMax, SZero, SZero, SZero, SMin, SZero, SZero, SZero},
                 1'b1, '{16'd65535, 16'd0, 16'd0, 16'd0}};
    rows[7]  = '{'{SZero, SMin, SZero, SZero, SZero, SMax, SZero, SZero, SZero},
                 1'b1, '{16'd0, 16'd65535, 16'd0, 16'd0}};
    // Full-scale yaw errors land on the clamp: the yaw term is 205 either way.
    rows[8]  = '{'{SZero, SZero, SMax, 16'sd4096, SZero, SZero, SMin, SZero, SZero},
                 1'b1, '{16'd4301, 16'd4301, 16'd3891, 16'd3891}};
    rows[9]  = '{'{SZero, SZero, SMin, 16'sd4096, SZero, SZero, SMax, SZero, SZero},
                 1'b1, '{16'd3891, 16'd3891, 16'd4301, 16'd4301}};
    rows[10] = '{'{SZero, SZero, SZero, SZero, SZero, SZero, SZero, SMax, SZero},
                 1'b1, '{16'd32767, 16'd32767, 16'd32767, 16'd32767}};
    rows[11] = '{'{SZero, SZero, SZero, SZero, SZero, SZero, SZero, SZero, SMin},
                 1'b1, '{16'd32768, 16'd32768, 16'd32768, 16'd32768}};
    // Half-LSB yaw terms: the positive tie rounds up, the negative one to zero.
    rows[12] = '{'{SZero, SZero, 16'sd1, 16'sd4096, SZero, SZero, SZero, SZero, SZero},
                 1'b0, '0};
    rows[13] = '{'{SZero, SZero, SZero, 16'sd4096, SZero, SZero, 16'sd1, SZero, SZero},
                 1'b0, '0};
    rows[14] = '{'{16'sd300, -16'sd200, 16'sd100, 16'sh2000, 16'sd250, -16'sd180,
                   16'sd60, 16'sh0800, -16'sh0800}, 1'b0, '0};
    rows[15] = '{'{16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
                   16'sh5555, 16'sh5555, 16'sh5555}, 1'b0, '0};
    rows[16] = '{'{16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA,
                   16'shAAAA, 16'shAAAA, 16'shAAAA}, 1'b0, '0};
    rows[17] = '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                   -16'sd1, -16'sd1}, 1'b0, '0};
    rows[18] = '{'{SMax, SMax, SMax, SMax, SMax, SMax, SMax, SMax, SMax}, 1'b0, '0};
    rows[19] = '{'{SZero, SZero, SZero, 16'sh1000, SMax, SMin, SMax, SMin, SMax},
                 1'b0, '0};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Middle third swaps the idle rates; the last third runs flat out.
      if (ph == 2) begin
        send_idle_pct = 55;
        stall_pct     = 20;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end

      if (ph == 0) begin
        for (int r = 0; r < NumRows; r++)
          send_sample(rows[r].stim, rows[r].known ? rows[r].drives : mix_motors(rows[r].stim));
      end else begin
        // Registers only change once the pipeline has run dry.
        settle();
        case (ph)
          // All gains off and a zero yaw clamp: drives follow the base only.
          1: program_gains(16'd0, 16'd0, 16'd0, 16'd0);
          // Top gains; the yaw limit loses its top bit and becomes 0x7FFF.
          2: program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: program_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          4: program_gains(16'($urandom_range(1024)), 16'($urandom_range(1024)),
                           16'($urandom_range(1024)), 16'($urandom_range(4096)));
          default: program_gains(16'($urandom_range(2048)), 16'($urandom_range(2048)),
                                 16'($urandom_range(2048)), 16'd1);
        endcase
      end

      for (int n = 0; n < ItemsPerPhase; n++) begin : random_samples
        in_item_t it;
        it = draw_attitude();
        send_sample(it, mix_motors(it));
      end
    end

    settle();
    fail_cnt += pending_drives.size();
    if (fail_cnt == 0)
      $display("tb_attitude_p_control_motor_mix passed");
    else
      $display("tb_attitude_p_control_motor_mix failed");
    $finish;
  end

endmodule
